// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// condition that must never be seen while out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

// ===== hw/rtl/tdop_pkg.sv =====
package tdop_pkg;

	localparam int ID_W        = 6;
	localparam int NODE_SPAN   = 1 << ID_W;
	localparam int IDX_W       = 3;
	localparam int MAX_RESULTS = 7;

	typedef struct packed {
		logic            func;
		logic [ID_W-1:0] src_node;
		logic [ID_W-1:0] dst_node;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]  hop_node;
		logic [IDX_W-1:0] hop_index;
		logic             last_hop;
		logic             id_error;
	} hop_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic emit_err;
		logic step;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic err;
		logic same;
		logic last;
	} dp_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WALK
	} ctl_state_t;

endpackage

// ===== hw/rtl/tdop_stream_if.sv =====
interface tdop_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tdop_datapath.sv =====
`include "assert_macros.svh"

module tdop_datapath import tdop_pkg::*; #(
	parameter int ROWS   = 3,
	parameter int COLS   = 4,
	parameter int LAYERS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   cmd,
	input  req_t       req,
	output dp_status_t status,
	output hop_t       hop
);

	localparam int PLANE = ROWS * COLS;
	localparam int TOTAL = PLANE * LAYERS;
	localparam int TW    = $clog2(TOTAL + 1);
	localparam int NW    = (TW > ID_W) ? TW : ID_W;
	localparam int LW    = $clog2(LAYERS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS);

	// id to coordinate decode, constant tables
	logic [LW-1:0] lay_lut [NODE_SPAN];
	logic [RW-1:0] row_lut [NODE_SPAN];
	logic [CW-1:0] col_lut [NODE_SPAN];

	for (genvar i = 0; i < NODE_SPAN; i++) begin : g_lut
		assign lay_lut[i] = LW'(i / PLANE);
		assign row_lut[i] = RW'((i % PLANE) / COLS);
		assign col_lut[i] = CW'(i % COLS);
	end

	logic          order_q;
	logic          err_q;
	logic          same_q;
	logic [LW-1:0] cur_l_q, end_l_q;
	logic [RW-1:0] cur_r_q, end_r_q;
	logic [CW-1:0] cur_c_q, end_c_q;
	logic [IDX_W-1:0] k_q;
	hop_t          hop_q;

	logic          err_in;
	logic          done_l, done_r, done_c;
	logic          step_l, step_r, step_c;
	logic [LW-1:0] nxt_l;
	logic [RW-1:0] nxt_r;
	logic [CW-1:0] nxt_c;
	logic [NW-1:0] nxt_id;
	logic          last;

	assign err_in = (NW'(req.src_node) >= NW'(TOTAL)) || (NW'(req.dst_node) >= NW'(TOTAL));

	assign done_l = (cur_l_q == end_l_q);
	assign done_r = (cur_r_q == end_r_q);
	assign done_c = (cur_c_q == end_c_q);

	// pick the first unfinished ring in the chosen order
	always_comb begin
		step_l = 1'b0;
		step_r = 1'b0;
		step_c = 1'b0;
		if (!order_q) begin
			if (!done_c) step_c = 1'b1;
			else if (!done_r) step_r = 1'b1;
			else step_l = 1'b1;
		end else begin
			if (!done_l) step_l = 1'b1;
			else if (!done_r) step_r = 1'b1;
			else step_c = 1'b1;
		end
	end

	always_comb begin
		nxt_l = cur_l_q;
		nxt_r = cur_r_q;
		nxt_c = cur_c_q;
		if (step_l) nxt_l = (cur_l_q == LW'(LAYERS - 1)) ? '0 : cur_l_q + LW'(1);
		if (step_r) nxt_r = (cur_r_q == RW'(ROWS - 1)) ? '0 : cur_r_q + RW'(1);
		if (step_c) nxt_c = (cur_c_q == CW'(COLS - 1)) ? '0 : cur_c_q + CW'(1);
	end

	assign nxt_id = NW'(nxt_l) * NW'(PLANE) + NW'(nxt_r) * NW'(COLS) + NW'(nxt_c);
	assign last   = ((nxt_l == end_l_q) && (nxt_r == end_r_q) && (nxt_c == end_c_q))
		|| (k_q == IDX_W'(MAX_RESULTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.load) begin
			k_q <= '0;
		end else if (cmd.step) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			order_q <= req.func;
			err_q   <= err_in;
			same_q  <= (req.src_node == req.dst_node);
			cur_l_q <= lay_lut[req.src_node];
			cur_r_q <= row_lut[req.src_node];
			cur_c_q <= col_lut[req.src_node];
			end_l_q <= lay_lut[req.dst_node];
			end_r_q <= row_lut[req.dst_node];
			end_c_q <= col_lut[req.dst_node];
		end else if (cmd.step) begin
			cur_l_q <= nxt_l;
			cur_r_q <= nxt_r;
			cur_c_q <= nxt_c;
		end
		if (cmd.emit_err) begin
			hop_q.hop_node  <= '0;
			hop_q.hop_index <= '0;
			hop_q.last_hop  <= 1'b1;
			hop_q.id_error  <= 1'b1;
		end else if (cmd.step) begin
			hop_q.hop_node  <= nxt_id[ID_W-1:0];
			hop_q.hop_index <= k_q;
			hop_q.last_hop  <= last;
			hop_q.id_error  <= 1'b0;
		end
	end

	assign status.err  = err_q;
	assign status.same = same_q;
	assign status.last = last;
	assign hop         = hop_q;

	// a step with every ring already at its target would invent a hop
	`ASSERT_NEVER(a_step_past_dst, clk, arst_n, cmd.step && done_l && done_r && done_c)
	`ASSERT_CLK(a_idx_advance, clk, arst_n,
		cmd.step && !cmd.load |=> k_q == IDX_W'($past(k_q) + IDX_W'(1)))
	`ASSERT_NEVER(a_cmd_overlap, clk, arst_n, (cmd.step || cmd.emit_err) && cmd.load)

endmodule

// ===== hw/rtl/tdop_controller.sv =====
module tdop_controller import tdop_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       hop_valid,
	input  logic       hop_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	// output register can take a new hop this cycle
	assign slot_free = !out_valid_q || hop_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (status.err) begin
					if (slot_free) state_d = ST_IDLE;
				end else if (status.same) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (slot_free && status.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = 1'b0;
		cmd.load     = 1'b0;
		cmd.emit_err = 1'b0;
		cmd.step     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_EVAL: begin
				cmd.emit_err = status.err && slot_free;
			end
			ST_WALK: begin
				cmd.step = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_err || cmd.step) out_valid_q <= 1'b1;
			else if (hop_ready) out_valid_q <= 1'b0;
		end
	end

	assign hop_valid = out_valid_q;

endmodule

// ===== hw/rtl/torus_dimension_order_path_generator_top.sv =====
// Dimension-order path generator for a unidirectional LAYERS x ROWS x COLS torus: each
// request on req names a route order and a source and destination id, and hop returns one
// transfer per node entered on the path, with hop_index counting from 0 and last_hop on the
// final one (at most seven hops). Equal ids return nothing; an id at or above the node count
// returns a single transfer with id_error set. One request is handled at a time: it is
// accepted in the idle state and evaluated in the evaluate state, then the walk state returns
// one hop per cycle while hop is drained; an id error's transfer is loaded while evaluating,
// and equal ids go back to idle from there.
module torus_dimension_order_path_generator_top import tdop_pkg::*; #(
	parameter int ROWS   = 3,
	parameter int COLS   = 4,
	parameter int LAYERS = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	tdop_stream_if.sink   req,
	tdop_stream_if.source hop
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	tdop_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.hop_valid (hop.valid),
		.hop_ready (hop.ready),
		.status    (status),
		.cmd       (cmd)
	);

	tdop_datapath #(
		.ROWS   (ROWS),
		.COLS   (COLS),
		.LAYERS (LAYERS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req.data),
		.status (status),
		.hop    (hop.data)
	);

endmodule
